[src/kcf_pkg.sv]
// Shared constants, types and helper functions for the keyword censor filter.
// Used by kcf_match, kcf_emit and keyword_censor_filter; no dependencies.
`default_nettype none
package kcf_pkg;

	localparam int MAX_PATTERN = 8;
	localparam int CENSOR_LEN  = 10;
	localparam int BYTE_W      = 8;
	localparam int CNT_W       = 4;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 64;
	localparam int LEN_W       = 4;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b1;

	typedef logic [BYTE_W-1:0] byte_t;

	// One group of result bytes made by a single input item.
	typedef struct packed {
		logic [CENSOR_LEN-1:0][BYTE_W-1:0] bytes;
		logic [CNT_W-1:0]                  count;
		logic                              msg_end;
	} burst_t;

	function automatic byte_t fold(input byte_t c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'h20;
		end
		return c;
	endfunction

	function automatic logic [CENSOR_LEN-1:0][BYTE_W-1:0] censor_text();
		logic [CENSOR_LEN-1:0][BYTE_W-1:0] t;
		t[0] = 8'h3C; // <
		t[1] = 8'h63; // c
		t[2] = 8'h65; // e
		t[3] = 8'h6E; // n
		t[4] = 8'h73; // s
		t[5] = 8'h6F; // o
		t[6] = 8'h72; // r
		t[7] = 8'h65; // e
		t[8] = 8'h64; // d
		t[9] = 8'h3E; // >
		return t;
	endfunction

endpackage
`default_nettype wire

[src/keyword_censor_filter.sv]
// Top level of the keyword censor filter: stream ports, configuration port.
// Depends on kcf_pkg, kcf_match and kcf_emit.
`default_nettype none
// Case-insensitive keyword censor. Text enters one byte per item; every
// occurrence of the configured pattern (up to 8 bytes, ASCII letters folded)
// leaves as the ten bytes "<censored>", leftmost and non-overlapping. Up to
// pattern length minus one bytes are held back until they can be decided;
// the byte marked tlast flushes them. A pattern length of zero passes text
// through. Writing either register discards pending bytes; write only while
// the block is idle. Rate: one item per cycle while each item yields at most
// one output byte and the output is ready. An item that yields more bytes (ten
// for a match, up to eight on a flush) holds off the input until its last byte
// leaves, because the output register sends one byte per cycle while ready and
// takes the next burst only as the last byte of the current one leaves. The
// first output byte appears in the cycle after its item is accepted.
module keyword_censor_filter (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [kcf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [kcf_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [7:0]                      s_axis_tdata,  // text_byte
	input  wire logic                            s_axis_tlast,  // text_last
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [7:0]                           m_axis_tdata,  // out_byte
	output logic                                 m_axis_tuser,  // run_last
	output logic                                 m_axis_tlast   // message_end
);

	logic            accept;
	kcf_pkg::burst_t burst;

	assign accept = s_axis_tvalid && s_axis_tready;

	kcf_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.text_byte (s_axis_tdata),
		.text_last (s_axis_tlast),
		.burst     (burst)
	);

	kcf_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept),
		.burst       (burst),
		.can_load    (s_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_byte    (m_axis_tdata),
		.run_last    (m_axis_tuser),
		.message_end (m_axis_tlast)
	);

`ifndef SYNTHESIS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output register");

	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
		else $error("message end not on last byte of a run");

	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tuser |=> m_axis_tvalid)
		else $error("burst broke off before its last byte");
`endif

endmodule
`default_nettype wire

[src/kcf_match.sv]
// Configuration registers, pending window and match logic of the censor filter.
// Depends on kcf_pkg; builds one result burst per accepted item.
`default_nettype none
module kcf_match (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [kcf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [kcf_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             accept,
	input  wire kcf_pkg::byte_t                   text_byte,
	input  wire logic                             text_last,
	output kcf_pkg::burst_t                       burst
);

	logic [kcf_pkg::CFG_DATA_W-1:0]  pattern_q;
	logic [kcf_pkg::LEN_W-1:0]       length_q;
	logic [kcf_pkg::CNT_W-1:0]       count_q;
	kcf_pkg::byte_t                  window_q [kcf_pkg::MAX_PATTERN];

	logic [kcf_pkg::LEN_W-1:0]       len;
	logic [kcf_pkg::CNT_W-1:0]       cnt0;
	logic [kcf_pkg::CNT_W-1:0]       cnt1;
	logic [kcf_pkg::CNT_W-1:0]       count_d;
	kcf_pkg::byte_t                  win_ext  [kcf_pkg::MAX_PATTERN];
	kcf_pkg::byte_t                  win_next [kcf_pkg::MAX_PATTERN];
	logic                            full;
	logic                            hit;
	logic                            shift;

	always_comb begin
		len = (length_q > kcf_pkg::LEN_W'(kcf_pkg::MAX_PATTERN))
			? kcf_pkg::LEN_W'(kcf_pkg::MAX_PATTERN) : length_q;
		cnt0 = (count_q >= len) ? '0 : count_q;
		cnt1 = cnt0 + kcf_pkg::CNT_W'(1);
		full = (cnt1 == len);

		// Drop the new byte into the first free slot.
		for (int i = 0; i < kcf_pkg::MAX_PATTERN; i++) begin
			win_ext[i] = (kcf_pkg::CNT_W'(i) == cnt0) ? text_byte : window_q[i];
		end
		for (int i = 0; i < kcf_pkg::MAX_PATTERN - 1; i++) begin
			win_next[i] = win_ext[i+1];
		end
		win_next[kcf_pkg::MAX_PATTERN-1] = win_ext[kcf_pkg::MAX_PATTERN-1];

		hit = full;
		for (int i = 0; i < kcf_pkg::MAX_PATTERN; i++) begin
			if (kcf_pkg::LEN_W'(i) < len && kcf_pkg::fold(win_ext[i]) !=
				kcf_pkg::fold(pattern_q[kcf_pkg::BYTE_W*i +: kcf_pkg::BYTE_W])) begin
				hit = 1'b0;
			end
		end

		burst.msg_end = text_last;
		burst.bytes   = '0;
		burst.count   = '0;
		count_d       = '0;
		shift         = 1'b0;
		for (int i = 0; i < kcf_pkg::MAX_PATTERN; i++) begin
			burst.bytes[i] = win_ext[i];
		end
		if (len == '0) begin
			burst.bytes[0] = text_byte;
			burst.count    = kcf_pkg::CNT_W'(1);
		end else if (hit) begin
			burst.bytes = kcf_pkg::censor_text();
			burst.count = kcf_pkg::CNT_W'(kcf_pkg::CENSOR_LEN);
		end else if (text_last) begin
			// Flush everything pending, oldest first.
			burst.count = cnt1;
		end else if (full) begin
			burst.count = kcf_pkg::CNT_W'(1);
			count_d     = len - kcf_pkg::LEN_W'(1);
			shift       = 1'b1;
		end else begin
			count_d = cnt1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			length_q  <= '0;
			count_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kcf_pkg::REG_PATTERN_BYTES:  pattern_q <= cfg_data;
				kcf_pkg::REG_PATTERN_LENGTH: length_q  <= cfg_data[kcf_pkg::LEN_W-1:0];
				default: ;
			endcase
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < kcf_pkg::MAX_PATTERN; i++) begin
				window_q[i] <= shift ? win_next[i] : win_ext[i];
			end
		end
	end

endmodule
`default_nettype wire

[src/kcf_emit.sv]
// Output register of the censor filter: holds one burst and sends it a byte at a time.
// Depends on kcf_pkg.
`default_nettype none
module kcf_emit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire kcf_pkg::burst_t   burst,
	output logic                   can_load,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output kcf_pkg::byte_t         out_byte,
	output logic                   run_last,
	output logic                   message_end
);

	logic [kcf_pkg::CENSOR_LEN-1:0][kcf_pkg::BYTE_W-1:0] bytes_q;
	logic [kcf_pkg::CNT_W-1:0]                           cnt_q;
	logic                                                end_q;
	logic                                                pop;

	assign out_valid   = (cnt_q != '0);
	assign pop         = out_valid && out_ready;
	assign run_last    = (cnt_q == kcf_pkg::CNT_W'(1));
	assign message_end = run_last && end_q;
	assign out_byte    = bytes_q[0];
	// A new burst may enter as the last byte of the current one leaves.
	assign can_load    = !out_valid || (run_last && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= burst.count;
		end else if (pop) begin
			cnt_q <= cnt_q - kcf_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= burst.bytes;
			end_q   <= burst.msg_end;
		end else if (pop) begin
			for (int i = 0; i < kcf_pkg::CENSOR_LEN - 1; i++) begin
				bytes_q[i] <= bytes_q[i+1];
			end
		end
	end

endmodule
`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for keyword_censor_filter: drives text messages in
// through the input stream and checks every output byte against a predictor.
// Depends on kcf_pkg and the keyword_censor_filter RTL.
module testbench;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam logic [8*kcf_pkg::CENSOR_LEN-1:0] REPLACEMENT = "<censored>";

	typedef struct packed {
		kcf_pkg::byte_t data;
		logic           run_last;
		logic           msg_end;
	} result_t;

	function automatic kcf_pkg::byte_t fold_case(input kcf_pkg::byte_t c);
		if (c >= "A" && c <= "Z") begin
			return c | 8'h20;
		end
		return c;
	endfunction

	// Censor predictor plus queue of output bytes still to arrive.
	class censor_scoreboard;
		logic [kcf_pkg::CFG_DATA_W-1:0] pattern_word;
		logic [kcf_pkg::LEN_W-1:0]      pattern_len;
		kcf_pkg::byte_t                 held[kcf_pkg::MAX_PATTERN];
		int unsigned                    held_count;
		result_t                        expected[$];
		int unsigned                    errors;

		function new();
			pattern_word = '0;
			pattern_len  = '0;
			held_count   = 0;
			errors       = 0;
		endfunction

		function void report_mismatch(string what);
			// cap the log on a badly broken build, keep counting
			if (errors < 100) begin
				$display("mismatch: %s", what);
			end
			errors++;
		endfunction

		function void write_reg(logic [kcf_pkg::CFG_IDX_W-1:0] idx,
			logic [kcf_pkg::CFG_DATA_W-1:0] value);
			case (idx)
				kcf_pkg::REG_PATTERN_BYTES: begin
					pattern_word = value;
					held_count   = 0;
				end
				kcf_pkg::REG_PATTERN_LENGTH: begin
					pattern_len = value[kcf_pkg::LEN_W-1:0];
					held_count  = 0;
				end
				default: ;
			endcase
		endfunction

		function void note_item(kcf_pkg::byte_t b, logic last);
			result_t     burst[$];
			result_t     r;
			int unsigned len;
			bit          hit;
			len = (pattern_len > kcf_pkg::MAX_PATTERN) ? kcf_pkg::MAX_PATTERN : pattern_len;
			r.run_last = 1'b0;
			r.msg_end  = 1'b0;
			if (len == 0) begin
				held_count = 0;
				r.data = b;
				burst.push_back(r);
			end else begin
				if (held_count >= len) begin
					held_count = 0;
				end
				held[held_count] = b;
				held_count++;
				if (held_count == len) begin
					hit = 1'b1;
					for (int i = 0; i < len; i++) begin
						if (fold_case(held[i]) != fold_case(pattern_word[8*i +: 8])) begin
							hit = 1'b0;
						end
					end
					if (hit) begin
						for (int i = 0; i < kcf_pkg::CENSOR_LEN; i++) begin
							r.data = REPLACEMENT[8*(kcf_pkg::CENSOR_LEN-1-i) +: 8];
							burst.push_back(r);
						end
						held_count = 0;
					end else begin
						// release the oldest byte, slide the rest down
						r.data = held[0];
						burst.push_back(r);
						for (int i = 1; i < held_count; i++) begin
							held[i-1] = held[i];
						end
						held_count--;
					end
				end
				if (last) begin
					for (int i = 0; i < held_count; i++) begin
						r.data = held[i];
						burst.push_back(r);
					end
					held_count = 0;
				end
			end
			if (burst.size() > 0) begin
				burst[burst.size()-1].run_last = 1'b1;
				burst[burst.size()-1].msg_end  = last;
			end
			foreach (burst[i]) begin
				expected.push_back(burst[i]);
			end
		endfunction

		function void check_result(kcf_pkg::byte_t data, logic run_last, logic msg_end);
			result_t want;
			if (expected.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h", data));
				return;
			end
			want = expected.pop_front();
			if (data !== want.data) begin
				report_mismatch($sformatf("out_byte %02h, want %02h", data, want.data));
			end
			if (run_last !== want.run_last) begin
				report_mismatch($sformatf("run_last %b, want %b on byte %02h",
					run_last, want.run_last, want.data));
			end
			if (msg_end !== want.msg_end) begin
				report_mismatch($sformatf("message_end %b, want %b on byte %02h",
					msg_end, want.msg_end, want.data));
			end
		endfunction
	endclass

	logic                           clk           = 1'b0;
	logic                           arst_n        = 1'b0;
	logic                           cfg_we        = 1'b0;
	logic [kcf_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [kcf_pkg::CFG_DATA_W-1:0] cfg_data      = '0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [7:0]                     s_axis_tdata  = '0;
	logic                           s_axis_tlast  = 1'b0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [7:0]                     m_axis_tdata;
	logic                           m_axis_tuser;
	logic                           m_axis_tlast;

	censor_scoreboard sb;
	bit               steady = 1'b0;
	int unsigned      cycles = 0;

	keyword_censor_filter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		end
		m_axis_tready <= steady || ($urandom_range(99) >= 22);
	end

	// Called at a rising edge; returns at the edge where the item is taken.
	task automatic send_item(input kcf_pkg::byte_t b, input logic last);
		while (!steady && $urandom_range(99) < 22) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(b, last);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.expected.size() != 0);
	endtask

	task automatic send_message(input kcf_pkg::byte_t msg[$], input int pause_at);
		for (int i = 0; i < msg.size(); i++) begin
			if (i == pause_at) begin
				wait_drained();
			end
			send_item(msg[i], i == msg.size() - 1);
		end
	endtask

	task automatic write_reg(input logic [kcf_pkg::CFG_IDX_W-1:0] idx,
		input logic [kcf_pkg::CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic set_pattern(input logic [kcf_pkg::CFG_DATA_W-1:0] word,
		input logic [kcf_pkg::LEN_W-1:0] len);
		// let the last burst leave before touching the registers
		wait_drained();
		repeat (4) @(posedge clk);
		write_reg(kcf_pkg::REG_PATTERN_BYTES, word);
		write_reg(kcf_pkg::REG_PATTERN_LENGTH,
			{{(kcf_pkg::CFG_DATA_W-kcf_pkg::LEN_W){1'b0}}, len});
	endtask

	function automatic kcf_pkg::byte_t letterish();
		kcf_pkg::byte_t c;
		c = kcf_pkg::byte_t'(8'h61 + $urandom_range(0, 2));
		if ($urandom_range(1)) begin
			c = c ^ 8'h20;
		end
		return ($urandom_range(99) < 70) ? c : kcf_pkg::byte_t'($urandom_range(0, 255));
	endfunction

	function automatic kcf_pkg::byte_t vary_case(input kcf_pkg::byte_t c);
		if (fold_case(c) >= "a" && fold_case(c) <= "z" && $urandom_range(1)) begin
			return c ^ 8'h20;
		end
		return c;
	endfunction

	initial begin
		kcf_pkg::byte_t                 msg[$];
		logic [kcf_pkg::CFG_DATA_W-1:0] word;
		logic [kcf_pkg::LEN_W-1:0]      len;
		int unsigned                    span;
		int unsigned                    sent;
		int unsigned                    target;
		int unsigned                    roll;
		int                             pause_at;
		logic [kcf_pkg::LEN_W-1:0]      len_plan[10];

		sb = new();
		len_plan = '{4'd8, 4'd1, 4'd15, 4'd3, 4'd0, 4'd5, 4'd2, 4'd9, 4'd4, 4'd0};
		len_plan[9] = kcf_pkg::LEN_W'($urandom_range(0, 15));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// pass-through straight out of reset
		msg = '{8'h00, 8'hFF};
		send_message(msg, -1);

		// pattern with a zero byte, folded match, flush of a short tail
		set_pattern(64'hFFFF_FFFF_FF00_4261, 4'd3);
		msg = '{8'h78, 8'h41, 8'h62, 8'h00, 8'h61, 8'h62};
		send_message(msg, -1);

		// one-byte pattern; bytes next to the letter range must not fold
		set_pattern(64'h1234_5678_9ABC_DE5A, 4'd1);
		msg = '{8'h7A, 8'h5A, 8'h5B, 8'h40};
		send_message(msg, -1);

		// oversized length acts as eight; match lands on the last byte
		set_pattern(64'h6867_6665_6463_6261, 4'd12);
		msg = '{8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48};
		send_message(msg, -1);

		// leftmost non-overlapping: "aaa" gives one match and a lone byte
		set_pattern(64'h0000_0000_0000_4161, 4'd2);
		msg = '{8'h61, 8'h61, 8'h61};
		send_message(msg, -1);

		for (int p = 0; p < 10; p++) begin
			len = len_plan[p];
			if (p == 2) begin
				word = '1;
			end else if (p == 3) begin
				word = '0;
			end else begin
				for (int i = 0; i < kcf_pkg::MAX_PATTERN; i++) begin
					word[8*i +: 8] = letterish();
				end
			end
			set_pattern(word, len);
			span = (len > kcf_pkg::MAX_PATTERN) ? kcf_pkg::MAX_PATTERN : len;
			steady = (p == 5);
			sent = 0;
			while (sent < 26) begin
				msg.delete();
				target = $urandom_range(1, 16);
				while (msg.size() < target) begin
					roll = $urandom_range(99);
					if (span > 0 && roll < 40) begin
						for (int i = 0; i < span; i++) begin
							msg.push_back(vary_case(word[8*i +: 8]));
						end
					end else if (span > 1 && roll < 55) begin
						// broken copy: a proper prefix of the pattern
						for (int i = 0; i < $urandom_range(1, span - 1); i++) begin
							msg.push_back(vary_case(word[8*i +: 8]));
						end
					end else if (roll < 80) begin
						msg.push_back(letterish());
					end else begin
						msg.push_back(kcf_pkg::byte_t'($urandom_range(0, 255)));
					end
				end
				// hold the sender mid-message once until all output is out
				pause_at = (p == 6 && sent == 0) ? msg.size() / 2 : -1;
				send_message(msg, pause_at);
				sent += msg.size();
			end
		end
		steady = 1'b0;

		wait_drained();
		repeat (12) @(posedge clk);
		if (sb.expected.size() != 0) begin
			sb.report_mismatch($sformatf("%0d bytes never arrived", sb.expected.size()));
		end
		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
